FILE: hw/rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define CRT_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("crt checker: property violated");

// expression must never be true outside reset
`define CRT_ASSERT_NEVER(label, clk, rst_n, expr) \
  `CRT_ASSERT(label, clk, rst_n, !(expr))

`endif

FILE: hw/rtl/crt_pkg.sv
// shared widths and constants for the two-congruence combiner
`default_nettype none
package crt_pkg;
  // port widths of the fields
  localparam int InW  = 32;
  localparam int OutW = 64;
  // working width of a modulus and of a double-width product
  localparam int W    = 32;
  localparam int DW   = 2 * W;
  // step counters of the serial units
  localparam int DivCntW = $clog2(DW + 1);
  localparam int MulCntW = $clog2(W + 1);
endpackage
`default_nettype wire

FILE: hw/rtl/crt_div.sv
// bit-serial restoring divider, double-width dividend by single-width divisor
`default_nettype none
module crt_div import crt_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [DW-1:0] dividend_i,
  input  wire logic [W-1:0]  divisor_i,
  output logic               done_o,
  output logic [DW-1:0]      quotient_o,
  output logic [W-1:0]       remainder_o
);
  logic [DivCntW-1:0] cnt_q;
  logic               done_q;
  logic [DW-1:0]      quo_q;
  logic [W-1:0]       rem_q;
  logic [W-1:0]       dvs_q;
  logic [W:0]         rem_sh;
  logic               ge;
  logic [W:0]         sub;

  // one quotient bit per cycle
  always_comb begin
    rem_sh = {rem_q, quo_q[DW-1]};
    ge     = rem_sh >= {1'b0, dvs_q};
    sub    = rem_sh - {1'b0, dvs_q};
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= DivCntW'(DW);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DivCntW'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath shift registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (cnt_q != '0) begin
      quo_q <= {quo_q[DW-2:0], ge};
      rem_q <= ge ? sub[W-1:0] : rem_sh[W-1:0];
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;
endmodule
`default_nettype wire

FILE: hw/rtl/crt_mul.sv
// bit-serial shift-add multiplier, single by single width
`default_nettype none
module crt_mul import crt_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [W-1:0] op_a_i,
  input  wire logic [W-1:0] op_b_i,
  output logic              done_o,
  output logic [DW-1:0]     product_o
);
  logic [MulCntW-1:0] cnt_q;
  logic               done_q;
  logic [DW-1:0]      mcand_q;
  logic [W-1:0]       mplier_q;
  logic [DW-1:0]      acc_q;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= MulCntW'(W);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == MulCntW'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  // one multiplier bit per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mcand_q  <= DW'(op_a_i);
      mplier_q <= op_b_i;
      acc_q    <= '0;
    end else if (cnt_q != '0) begin
      if (mplier_q[0]) begin
        acc_q <= acc_q + mcand_q;
      end
      mcand_q  <= {mcand_q[DW-2:0], 1'b0};
      mplier_q <= {1'b0, mplier_q[W-1:1]};
    end
  end

  assign done_o    = done_q;
  assign product_o = acc_q;
endmodule
`default_nettype wire

FILE: hw/rtl/crt_combine_two_congruences.sv
// top level: combines two congruences into one
// Solves x = a mod n, x = b mod m for the least x below lcm(n, m). A transaction is
// taken when start is high and busy is low; busy stays high through the one-cycle result
// strobe done_o, which cannot be held off. All multiplications and divisions run through one
// bit-serial divider and one bit-serial multiplier. The time to the result strobe grows with the
// number of Euclid steps for gcd(n, m) and with those of the modular inverse. A zero modulus
// gives the strobe in the cycle right after acceptance, with no_solution set.
`default_nettype none
module crt_combine_two_congruences import crt_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  output logic                 busy,
  input  wire logic [InW-1:0]  residue_first_i,
  input  wire logic [InW-1:0]  modulus_first_i,
  input  wire logic [InW-1:0]  residue_second_i,
  input  wire logic [InW-1:0]  modulus_second_i,
  output logic                 done_o,
  output logic [OutW-1:0]      combined_residue_o,
  output logic [OutW-1:0]      combined_modulus_o,
  output logic                 no_solution_o
);
  typedef enum logic [4:0] {
    S_IDLE, S_AMOD, S_BMOD, S_GCD_CHK, S_GCD, S_NG, S_MG, S_LCM, S_DIFF, S_RMOD,
    S_VMOD, S_EE_CHK, S_EE_Q, S_EE_M, S_EE_R, S_T1, S_T2, S_X, S_OUT
  } state_e;

  state_e         state_q;
  logic           div_go_q, mul_go_q;
  logic [DW-1:0]  div_dd_q;
  logic [W-1:0]   div_dv_q, mul_a_q, mul_b_q;
  logic           div_done, mul_done;
  logic [DW-1:0]  div_quo, mul_prod;
  logic [W-1:0]   div_rem;
  logic [W-1:0]   a_q, b_q, n_q, m_q, x_q, y_q, g_q, ng_q, mg_q, r_q, s0_q, s1_q, rr_q;
  logic [DW-1:0]  lcm_q;
  logic [DW-1:0]  res_q, mod_q;
  logic           nosol_q, done_q;
  logic [W-1:0]   diff, r_adj, ts;
  logic [W:0]     ts_wrap;

  crt_div u_div (
    .clk_i, .rst_ni, .start_i(div_go_q), .dividend_i(div_dd_q), .divisor_i(div_dv_q),
    .done_o(div_done), .quotient_o(div_quo), .remainder_o(div_rem)
  );

  crt_mul u_mul (
    .clk_i, .rst_ni, .start_i(mul_go_q), .op_a_i(mul_a_q), .op_b_i(mul_b_q),
    .done_o(mul_done), .product_o(mul_prod)
  );

  // residue difference, sign fix of r and the modular update of the inverse coefficient
  always_comb begin
    diff    = (a_q >= b_q) ? a_q - b_q : b_q - a_q;
    r_adj   = ((a_q >= b_q) && (div_rem != '0)) ? mg_q - div_rem : div_rem;
    ts_wrap = ({1'b0, s0_q} + {1'b0, mg_q}) - {1'b0, div_rem};
    ts      = (s0_q >= div_rem) ? s0_q - div_rem : ts_wrap[W-1:0];
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      div_go_q <= 1'b0;
      mul_go_q <= 1'b0;
      done_q   <= 1'b0;
      div_dd_q <= '0;
      div_dv_q <= '0;
      mul_a_q  <= '0;
      mul_b_q  <= '0;
      res_q    <= '0;
      mod_q    <= '0;
      nosol_q  <= 1'b0;
      a_q      <= '0;
      b_q      <= '0;
      n_q      <= '0;
      m_q      <= '0;
      x_q      <= '0;
      y_q      <= '0;
      g_q      <= '0;
      ng_q     <= '0;
      mg_q     <= '0;
      r_q      <= '0;
      s0_q     <= '0;
      s1_q     <= '0;
      rr_q     <= '0;
      lcm_q    <= '0;
    end else begin
      div_go_q <= 1'b0;
      mul_go_q <= 1'b0;
      done_q   <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start) begin
            a_q <= residue_first_i[W-1:0];
            n_q <= modulus_first_i[W-1:0];
            b_q <= residue_second_i[W-1:0];
            m_q <= modulus_second_i[W-1:0];
            if (modulus_first_i[W-1:0] == '0 || modulus_second_i[W-1:0] == '0) begin
              res_q   <= '0;
              mod_q   <= '0;
              nosol_q <= 1'b1;
              done_q  <= 1'b1;
              state_q <= S_OUT;
            end else begin
              div_dd_q <= DW'(residue_first_i[W-1:0]);
              div_dv_q <= modulus_first_i[W-1:0];
              div_go_q <= 1'b1;
              state_q  <= S_AMOD;
            end
          end
        end
        S_AMOD: begin
          if (div_done) begin
            a_q      <= div_rem;
            div_dd_q <= DW'(b_q);
            div_dv_q <= m_q;
            div_go_q <= 1'b1;
            state_q  <= S_BMOD;
          end
        end
        S_BMOD: begin
          if (div_done) begin
            b_q     <= div_rem;
            x_q     <= n_q;
            y_q     <= m_q;
            state_q <= S_GCD_CHK;
          end
        end
        // euclid loop for the gcd
        S_GCD_CHK: begin
          div_go_q <= 1'b1;
          if (y_q == '0) begin
            g_q      <= x_q;
            div_dd_q <= DW'(n_q);
            div_dv_q <= x_q;
            state_q  <= S_NG;
          end else begin
            div_dd_q <= DW'(x_q);
            div_dv_q <= y_q;
            state_q  <= S_GCD;
          end
        end
        S_GCD: begin
          if (div_done) begin
            x_q     <= y_q;
            y_q     <= div_rem;
            state_q <= S_GCD_CHK;
          end
        end
        S_NG: begin
          if (div_done) begin
            ng_q     <= div_quo[W-1:0];
            div_dd_q <= DW'(m_q);
            div_dv_q <= g_q;
            div_go_q <= 1'b1;
            state_q  <= S_MG;
          end
        end
        S_MG: begin
          if (div_done) begin
            mg_q     <= div_quo[W-1:0];
            mul_a_q  <= ng_q;
            mul_b_q  <= m_q;
            mul_go_q <= 1'b1;
            state_q  <= S_LCM;
          end
        end
        S_LCM: begin
          if (mul_done) begin
            lcm_q    <= mul_prod;
            div_dd_q <= DW'(diff);
            div_dv_q <= g_q;
            div_go_q <= 1'b1;
            state_q  <= S_DIFF;
          end
        end
        S_DIFF: begin
          if (div_done) begin
            if (div_rem != '0) begin
              res_q   <= '0;
              mod_q   <= lcm_q;
              nosol_q <= 1'b1;
              done_q  <= 1'b1;
              state_q <= S_OUT;
            end else begin
              div_dd_q <= div_quo;
              div_dv_q <= mg_q;
              div_go_q <= 1'b1;
              state_q  <= S_RMOD;
            end
          end
        end
        S_RMOD: begin
          if (div_done) begin
            r_q      <= r_adj;
            div_dd_q <= DW'(ng_q);
            div_dv_q <= mg_q;
            div_go_q <= 1'b1;
            state_q  <= S_VMOD;
          end
        end
        S_VMOD: begin
          if (div_done) begin
            x_q     <= mg_q;
            y_q     <= div_rem;
            s0_q    <= '0;
            s1_q    <= W'(1);
            state_q <= S_EE_CHK;
          end
        end
        // extended euclid, coefficients kept modulo m/g
        S_EE_CHK: begin
          if (y_q == '0) begin
            mul_a_q  <= r_q;
            mul_b_q  <= s0_q;
            mul_go_q <= 1'b1;
            state_q  <= S_T1;
          end else begin
            div_dd_q <= DW'(x_q);
            div_dv_q <= y_q;
            div_go_q <= 1'b1;
            state_q  <= S_EE_Q;
          end
        end
        S_EE_Q: begin
          if (div_done) begin
            rr_q     <= div_rem;
            mul_a_q  <= div_quo[W-1:0];
            mul_b_q  <= s1_q;
            mul_go_q <= 1'b1;
            state_q  <= S_EE_M;
          end
        end
        S_EE_M: begin
          if (mul_done) begin
            div_dd_q <= mul_prod;
            div_dv_q <= mg_q;
            div_go_q <= 1'b1;
            state_q  <= S_EE_R;
          end
        end
        S_EE_R: begin
          if (div_done) begin
            x_q     <= y_q;
            y_q     <= rr_q;
            s0_q    <= s1_q;
            s1_q    <= ts;
            state_q <= S_EE_CHK;
          end
        end
        // t = r * inverse mod m/g, then x = a + n * t
        S_T1: begin
          if (mul_done) begin
            div_dd_q <= mul_prod;
            div_dv_q <= mg_q;
            div_go_q <= 1'b1;
            state_q  <= S_T2;
          end
        end
        S_T2: begin
          if (div_done) begin
            mul_a_q  <= n_q;
            mul_b_q  <= div_rem;
            mul_go_q <= 1'b1;
            state_q  <= S_X;
          end
        end
        S_X: begin
          if (mul_done) begin
            res_q   <= DW'(a_q) + mul_prod;
            mod_q   <= lcm_q;
            nosol_q <= 1'b0;
            done_q  <= 1'b1;
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy               = (state_q != S_IDLE);
  assign done_o             = done_q;
  assign combined_residue_o = OutW'(res_q);
  assign combined_modulus_o = OutW'(mod_q);
  assign no_solution_o      = nosol_q;
endmodule
`default_nettype wire

FILE: hw/rtl/crt_checker.sv
// port-level checker for the two-congruence combiner, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module crt_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done_o,
  input wire logic [63:0] combined_residue_o,
  input wire logic [63:0] combined_modulus_o,
  input wire logic        no_solution_o
);
  // a result only appears inside a transaction
  `CRT_ASSERT(a_done_busy, clk_i, rst_ni, done_o |-> busy)
  // accepted transaction makes the block busy
  `CRT_ASSERT(a_start_busy, clk_i, rst_ni, (start && !busy) |=> busy)
  // exactly one strobe, then back to idle
  `CRT_ASSERT(a_done_once, clk_i, rst_ni, done_o |=> (!done_o && !busy))
  // solved residue lies below the combined modulus
  `CRT_ASSERT(a_res_range, clk_i, rst_ni,
              (done_o && !no_solution_o) |-> (combined_residue_o < combined_modulus_o))
  // unsolvable result carries a zero residue
  `CRT_ASSERT_NEVER(a_nosol_zero, clk_i, rst_ni,
                    done_o && no_solution_o && (combined_residue_o != '0))
endmodule

bind crt_combine_two_congruences crt_checker u_crt_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .done_o(done_o),
  .combined_residue_o(combined_residue_o), .combined_modulus_o(combined_modulus_o),
  .no_solution_o(no_solution_o)
);
`default_nettype wire

FILE: tb/crt_combine_two_congruences_tb.sv
// testbench for the two-congruence combiner: random and directed congruence pairs
`timescale 1ns / 100ps
`default_nettype none
module crt_combine_two_congruences_tb;
  import crt_pkg::*;

  typedef struct packed {
    logic [InW-1:0] res_a;
    logic [InW-1:0] mod_n;
    logic [InW-1:0] res_b;
    logic [InW-1:0] mod_m;
  } congr_pair_t;

  typedef struct packed {
    logic [OutW-1:0] x;
    logic [OutW-1:0] lcm;
    logic            nosol;
  } solution_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic [InW-1:0]       residue_first_i;
  logic [InW-1:0]       modulus_first_i;
  logic [InW-1:0]       residue_second_i;
  logic [InW-1:0]       modulus_second_i;
  logic                 done_o;
  logic [OutW-1:0]      combined_residue_o;
  logic [OutW-1:0]      combined_modulus_o;
  logic                 no_solution_o;

  congr_pair_t pair_q[$];
  solution_t   solution_q[$];
  int          mismatch_cnt;
  int          idle_left;
  bit          idle_on;
  bit          stim_done;

  crt_combine_two_congruences i_dut (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .residue_first_i,
    .modulus_first_i,
    .residue_second_i,
    .modulus_second_i,
    .done_o,
    .combined_residue_o,
    .combined_modulus_o,
    .no_solution_o
  );

  // clock
  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
    logic [63:0] r;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    return x;
  endfunction

  // inverse of v modulo md by extended euclid
  function automatic logic [63:0] mod_inverse(logic [63:0] v, logic [63:0] md);
    longint r0, r1, s0, s1, q, tr, ts;
    r0 = md;
    r1 = v % md;
    s0 = 0;
    s1 = 1;
    if (md == 1) return 64'(0);
    while (r1 != 0) begin
      q = r0 / r1;
      tr = r0 - q * r1;
      ts = s0 - q * s1;
      r0 = r1; r1 = tr;
      s0 = s1; s1 = ts;
    end
    if (s0 < 0) s0 += md;
    return 64'(s0) % md;
  endfunction

  function automatic solution_t solve_pair(congr_pair_t p);
    solution_t   s;
    logic [63:0] a, n, b, m, g, ng, mg, diff, r, t;
    a = 64'(p.res_a); n = 64'(p.mod_n); b = 64'(p.res_b); m = 64'(p.mod_m);
    s = '0;
    s.nosol = 1'b1;
    if (n == 0 || m == 0) return s;
    a = a % n;
    b = b % m;
    g = gcd64(n, m);
    ng = n / g;
    mg = m / g;
    s.lcm = ng * m;
    diff = (a >= b) ? a - b : b - a;
    if (diff % g != 0) return s;
    r = (diff / g) % mg;
    if (a >= b) r = (mg - r) % mg;
    t = (r * mod_inverse(ng % mg, mg)) % mg;
    s.x = a + n * t;
    s.nosol = 1'b0;
    return s;
  endfunction

  function automatic logic [31:0] rand_mod();
    case ($urandom_range(0, 4))
      0: return $urandom_range(1, 16);
      1: return $urandom_range(1, 1000);
      2: return $urandom_range(1, 65535);
      3: return ($urandom_range(1, 4000)) << $urandom_range(0, 20);
      default: return $urandom;
    endcase
  endfunction

  // stimulus: directed corners, then random pairs, many of them solvable
  initial begin
    congr_pair_t p;
    logic [31:0] g, k;
    p = '{32'd2, 32'd3, 32'd3, 32'd5}; pair_q.insert(pair_q.size(), p);
    p = '{32'd0, 32'd1, 32'd0, 32'd1}; pair_q.insert(pair_q.size(), p);
    p = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE};
    pair_q.insert(pair_q.size(), p);
    p = '{32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'd5, 32'hFFFF_FFFB};
    pair_q.insert(pair_q.size(), p);
    p = '{32'd1, 32'd4, 32'd2, 32'd6}; pair_q.insert(pair_q.size(), p);
    p = '{32'd3, 32'd4, 32'd1, 32'd6}; pair_q.insert(pair_q.size(), p);
    p = '{32'd100, 32'd7, 32'd200, 32'd11}; pair_q.insert(pair_q.size(), p);
    p = '{32'd5, 32'd0, 32'd3, 32'd7}; pair_q.insert(pair_q.size(), p);
    p = '{32'd5, 32'd7, 32'd3, 32'd0}; pair_q.insert(pair_q.size(), p);
    p = '{32'd0, 32'd0, 32'd0, 32'd0}; pair_q.insert(pair_q.size(), p);
    p = '{32'd12, 32'd12, 32'd0, 32'd12}; pair_q.insert(pair_q.size(), p);
    p = '{32'h8000_0000, 32'h8000_0000, 32'd0, 32'h4000_0000};
    pair_q.insert(pair_q.size(), p);
    p = '{32'd2971215073, 32'd2971215073, 32'd1836311903, 32'd1836311903};
    pair_q.insert(pair_q.size(), p);
    p = '{32'd7, 32'd2971215073, 32'd9, 32'd1836311903}; pair_q.insert(pair_q.size(), p);
    p = '{32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA};
    pair_q.insert(pair_q.size(), p);
    for (int i = 0; i < 800; i++) begin
      p.mod_n = rand_mod();
      p.mod_m = rand_mod();
      case ($urandom_range(0, 3))
        0: begin
          p.res_a = $urandom;
          p.res_b = $urandom;
        end
        1: begin
          p.res_a = $urandom_range(0, 50);
          p.res_b = $urandom_range(0, 50);
        end
        default: begin
          // common factor with residues that agree modulo it, so the pair is often solvable
          g = $urandom_range(1, 1000);
          k = $urandom;
          p.mod_n = g * $urandom_range(1, 65535);
          p.mod_m = g * $urandom_range(1, 65535);
          if (p.mod_n == 0) p.mod_n = g;
          if (p.mod_m == 0) p.mod_m = g;
          p.res_a = k % p.mod_n + p.mod_n * $urandom_range(0, 1);
          p.res_b = k % g + g * $urandom_range(0, 30);
        end
      endcase
      if ($urandom_range(0, 40) == 0) p.mod_n = 0;
      pair_q.insert(pair_q.size(), p);
    end
  end

  // reset
  initial begin
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // driver: one transaction per start, random idle bursts except near the end
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start            <= 1'b0;
      residue_first_i  <= '0;
      modulus_first_i  <= '0;
      residue_second_i <= '0;
      modulus_second_i <= '0;
      idle_left        <= 0;
      idle_on          <= 1'b0;
      stim_done        <= 1'b0;
    end else begin
      automatic bit accepted = start && !busy;
      automatic bit can_go;
      if (accepted) solution_q.insert(solution_q.size(),
                                      solve_pair({residue_first_i, modulus_first_i,
                                                  residue_second_i, modulus_second_i}));
      can_go = !start || accepted;
      if (can_go) begin
        if (idle_left > 0) begin
          idle_left <= idle_left - 1;
          start     <= 1'b0;
        end else if (pair_q.size() == 0) begin
          start     <= 1'b0;
          stim_done <= 1'b1;
        end else if (pair_q.size() > 60 && $urandom_range(0, 3) == 0) begin
          idle_left <= $urandom_range(1, 18) - 1;
          start     <= 1'b0;
        end else begin
          automatic congr_pair_t p = pair_q.pop_front();
          start            <= 1'b1;
          residue_first_i  <= p.res_a;
          modulus_first_i  <= p.mod_n;
          residue_second_i <= p.res_b;
          modulus_second_i <= p.mod_m;
        end
      end
    end
  end

  // monitor: compare each result strobe with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (solution_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected result at %0t", $time);
      end else begin
        automatic solution_t s = solution_q.pop_front();
        if (s.x !== combined_residue_o || s.lcm !== combined_modulus_o ||
            s.nosol !== no_solution_o) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: exp x=%0d lcm=%0d ns=%0b got x=%0d lcm=%0d ns=%0b",
                     s.x, s.lcm, s.nosol, combined_residue_o, combined_modulus_o,
                     no_solution_o);
        end
      end
    end
  end

  // end of run
  initial begin
    mismatch_cnt = 0;
    wait (stim_done === 1'b1);
    while (solution_q.size() != 0 || busy) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (mismatch_cnt == 0 && solution_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
`default_nettype wire
